/* rtl/framed_command_parser_with_latch_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the framed command parser
// Shared property wrappers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_PARSER_WITH_LATCH_DEFINES_SVH
`define FRAMED_COMMAND_PARSER_WITH_LATCH_DEFINES_SVH

// same-cycle implication
`define FCP_ASSERT_NOW(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("fcp assertion failed");

// next-cycle implication
`define FCP_ASSERT_NEXT(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("fcp assertion failed");

`endif

/* rtl/fcp_pkg.sv */
// ----------------------------------------------------------------------------
// fcp_pkg
// Types, codes and helpers shared by the framed command parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcp_pkg;

	localparam logic [7:0] SYNC_A   = 8'hAA;
	localparam logic [7:0] SYNC_B   = 8'h55;
	localparam logic [7:0] TYPE_CMD = 8'h01;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_GOTA = 3'd1;
	localparam logic [2:0] PH_GOTB = 3'd2;
	localparam logic [2:0] PH_TYPE = 3'd3;
	localparam logic [2:0] PH_LOW  = 3'd4;
	localparam logic [2:0] PH_HIGH = 3'd5;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_GOOD = 2'd1;
	localparam logic [1:0] EV_BAD  = 2'd2;

	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 128;
	localparam int M_USER_W = 2;
	localparam int PAD_W    = 5;

	typedef struct packed {
		logic [2:0]  phase;
		logic [7:0]  cmd_low;
		logic [7:0]  cmd_high;
		logic [8:0]  cand_angle;
		logic [7:0]  run;
		logic [8:0]  lock_angle;
		logic        lock;
		logic [31:0] bytes;
		logic [31:0] good;
		logic [31:0] bad;
	} fcp_state_t;

	typedef struct packed {
		logic [1:0] frame_event;
		fcp_state_t st;
	} fcp_result_t;

	function automatic logic [8:0] angle_of(input logic [7:0] lo, input logic [7:0] hi);
		logic [8:0] ang;
		ang = 9'd0;
		if (hi == 8'd0) begin
			unique case (lo)
				8'd1:    ang = 9'd90;
				8'd2:    ang = 9'd180;
				8'd3:    ang = 9'd270;
				8'd4:    ang = 9'd360;
				default: ang = 9'd0;
			endcase
		end
		return ang;
	endfunction

endpackage

/* rtl/fcp_core.sv */
// ----------------------------------------------------------------------------
// fcp_core
// Frame parser state, angle confirmation latch, counters and threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	input  logic                 clear_state,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_data,
	output fcp_pkg::fcp_state_t  st,
	output fcp_pkg::fcp_result_t res
);
	import fcp_pkg::*;

	fcp_state_t st_q;
	fcp_state_t nxt;
	logic [7:0] thresh_q;
	logic [1:0] ev;
	logic [7:0] sum;
	logic [8:0] ang;
	logic       frame_ok;
	logic [8:0] cand_n;
	logic [7:0] run_n;

	assign sum      = st_q.cmd_low + st_q.cmd_high;
	assign ang      = angle_of(st_q.cmd_low, st_q.cmd_high);
	assign frame_ok = (rx_byte == sum) && (ang != 9'd0);

	always_comb begin
		cand_n = st_q.cand_angle;
		run_n  = st_q.run;
		if (ang == st_q.cand_angle) begin
			if (st_q.run < thresh_q) begin
				run_n = st_q.run + 8'd1;
			end
		end else begin
			cand_n = ang;
			run_n  = 8'd1;
		end
	end

	always_comb begin
		nxt = st_q;
		ev  = EV_NONE;
		if (clear_state) begin
			nxt = '0;
		end else begin
			nxt.bytes = st_q.bytes + 32'd1;
			unique case (st_q.phase)
				PH_HUNT: begin
					if (rx_byte == SYNC_A) nxt.phase = PH_GOTA;
				end
				PH_GOTA: begin
					priority if (rx_byte == SYNC_B) nxt.phase = PH_GOTB;
					else if (rx_byte != SYNC_A) nxt.phase = PH_HUNT;
				end
				PH_GOTB: begin
					priority if (rx_byte == TYPE_CMD) nxt.phase = PH_TYPE;
					else if (rx_byte == SYNC_A) nxt.phase = PH_GOTA;
					else nxt.phase = PH_HUNT;
				end
				PH_TYPE: begin
					nxt.cmd_low = rx_byte;
					nxt.phase   = PH_LOW;
				end
				PH_LOW: begin
					nxt.cmd_high = rx_byte;
					nxt.phase    = PH_HIGH;
				end
				PH_HIGH: begin
					if (frame_ok) begin
						ev       = EV_GOOD;
						nxt.good = st_q.good + 32'd1;
						if (!st_q.lock) begin
							nxt.cand_angle = cand_n;
							nxt.run        = run_n;
							if (run_n >= thresh_q) begin
								nxt.lock_angle = ang;
								nxt.lock       = 1'b1;
							end
						end
					end else begin
						ev      = EV_BAD;
						nxt.bad = st_q.bad + 32'd1;
					end
					nxt.phase = (rx_byte == SYNC_A) ? PH_GOTA : PH_HUNT;
				end
				default: nxt.phase = PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 8'd1;
		end else if (cfg_we) begin
			thresh_q <= cfg_data;
		end
	end

	assign st              = st_q;
	assign res.frame_event = ev;
	assign res.st          = nxt;

endmodule

/* rtl/fcp_out_reg.sv */
// ----------------------------------------------------------------------------
// fcp_out_reg
// Result register on the master stream: packs and holds one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcp_out_reg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  fcp_pkg::fcp_result_t              res,
	output logic                              room,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [fcp_pkg::M_DATA_W-1:0]      m_axis_tdata,
	output logic [fcp_pkg::M_USER_W-1:0]      m_axis_tuser
);
	import fcp_pkg::*;

	logic                valid_q;
	logic [M_DATA_W-1:0] data_q;
	logic [M_USER_W-1:0] user_q;

	assign room = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && room) begin
			data_q <= {{PAD_W{1'b0}}, res.st.bad, res.st.good, res.st.bytes, res.st.run,
				res.st.cand_angle, res.st.lock_angle, res.st.lock};
			user_q <= res.frame_event;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;

endmodule

/* rtl/framed_command_parser_with_latch.sv */
// ----------------------------------------------------------------------------
// framed_command_parser_with_latch
// Serial byte frame parser (AA 55 01 lo hi sum) with angle confirmation latch.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per item in tdata; tuser high clears
//   parser, latch and counters and the byte is dropped.
//   m_axis returns exactly one result item per input item, in order: tuser is
//   the frame event (none, accepted, rejected), tdata the state after the byte.
//   cfg_valid/cfg_data write the confirm threshold (reset value 1); write it
//   only while no item is in flight. cfg_ready is always high.
//   An accepted input item is held in the input register, then the state
//   update loads its result into the result register.
//   Throughput: one item per cycle while m_axis does not stall.
//   Reset clears all state and counters and empties both registers.
//   When m_axis stalls, the result register holds; the input register still
//   takes one more item, then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "framed_command_parser_with_latch_defines.svh"

module framed_command_parser_with_latch (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [fcp_pkg::S_DATA_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
	input  logic                          s_axis_tuser,  // [0] clear_state
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [0] latched, [9:1] latched_angle, [18:10] candidate_angle,
	// [26:19] repeat_count, [58:27] bytes_seen, [90:59] valid_frames,
	// [122:91] rejected_frames, [127:123] zero
	output logic [fcp_pkg::M_DATA_W-1:0]  m_axis_tdata,
	output logic [fcp_pkg::M_USER_W-1:0]  m_axis_tuser,  // [1:0] frame_event
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_data
);
	import fcp_pkg::*;

	logic                valid_s1;
	logic [S_DATA_W-1:0] byte_s1;
	logic                clr_s1;
	logic                room;
	logic                step;
	fcp_state_t          st;
	fcp_result_t         res;

	assign step          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			clr_s1  <= s_axis_tuser;
		end
	end

	fcp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rx_byte     (byte_s1),
		.clear_state (clr_s1),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.st          (st),
		.res         (res)
	);

	fcp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step),
		.res           (res),
		.room          (room),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	`FCP_ASSERT_NEXT(a_latch_holds, clk, arst_n, st.lock && !(step && clr_s1), st.lock)
	`FCP_ASSERT_NOW(a_lock_angle_set, clk, arst_n, st.lock, st.lock_angle != 9'd0)
	`FCP_ASSERT_NEXT(a_byte_count, clk, arst_n, step && !clr_s1,
		st.bytes == $past(st.bytes) + 32'd1)
	`FCP_ASSERT_NOW(a_event_code, clk, arst_n, m_axis_tvalid,
		m_axis_tuser == EV_NONE || m_axis_tuser == EV_GOOD || m_axis_tuser == EV_BAD)

endmodule

/* tb/framed_command_parser_with_latch_checker.sv */
// ----------------------------------------------------------------------------
// framed_command_parser_with_latch_checker
// Watches the byte, result and threshold channels of the frame parser. It
// keeps its own copy of parser, latch and counter state, computes the status
// item that each accepted byte must produce, and compares every returned item
// field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_command_parser_with_latch_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
	input  logic         s_axis_tuser,   // [0] clear_state
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] latched, [9:1] latched_angle, [18:10] candidate_angle,
	// [26:19] repeat_count, [58:27] bytes_seen, [90:59] valid_frames,
	// [122:91] rejected_frames, [127:123] zero
	input  logic [127:0] m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,   // [1:0] frame_event
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [7:0]   cfg_data,
	output int           mismatches,
	output int           outstanding
);

	import fcp_pkg::*;

	typedef struct packed {
		logic [1:0]  frame_event;
		logic [4:0]  pad;
		logic [31:0] rejected;
		logic [31:0] accepted;
		logic [31:0] byte_count;
		logic [7:0]  repeat_count;
		logic [8:0]  cand_angle;
		logic [8:0]  lock_angle;
		logic        latched;
	} status_item_t;

	status_item_t status_q[$];

	logic [7:0]  threshold;
	logic [2:0]  phase;
	logic [7:0]  cmd_lo;
	logic [7:0]  cmd_hi;
	logic [8:0]  cand_angle;
	logic [7:0]  run_len;
	logic [8:0]  lock_angle;
	logic        latched;
	logic [31:0] byte_count;
	logic [31:0] accepted;
	logic [31:0] rejected;

	function automatic logic [8:0] command_angle(input logic [7:0] lo, input logic [7:0] hi);
		if (hi == 8'd0 && lo >= 8'd1 && lo <= 8'd4)
			return {1'b0, lo} * 9'd90;
		return 9'd0;
	endfunction

	task automatic clear_parser();
		phase      = PH_HUNT;
		cmd_lo     = 8'd0;
		cmd_hi     = 8'd0;
		cand_angle = 9'd0;
		run_len    = 8'd0;
		lock_angle = 9'd0;
		latched    = 1'b0;
		byte_count = 32'd0;
		accepted   = 32'd0;
		rejected   = 32'd0;
	endtask

	task automatic credit_angle(input logic [8:0] ang);
		accepted = accepted + 32'd1;
		if (!latched) begin
			if (ang == cand_angle) begin
				if (run_len < threshold)
					run_len = run_len + 8'd1;
			end else begin
				cand_angle = ang;
				run_len    = 8'd1;
			end
			if (run_len >= threshold) begin
				lock_angle = ang;
				latched    = 1'b1;
			end
		end
	endtask

	task automatic advance_parser(input logic [7:0] rx, input logic clr,
			output status_item_t item);
		logic [1:0] ev;
		logic [7:0] sum;
		logic [8:0] ang;
		ev = EV_NONE;
		if (clr) begin
			clear_parser();
		end else begin
			byte_count = byte_count + 32'd1;
			case (phase)
				PH_HUNT: begin
					if (rx == SYNC_A)
						phase = PH_GOTA;
				end
				PH_GOTA: begin
					if (rx == SYNC_B)
						phase = PH_GOTB;
					else if (rx != SYNC_A)
						phase = PH_HUNT;
				end
				PH_GOTB: begin
					if (rx == TYPE_CMD)
						phase = PH_TYPE;
					else if (rx == SYNC_A)
						phase = PH_GOTA;
					else
						phase = PH_HUNT;
				end
				PH_TYPE: begin
					cmd_lo = rx;
					phase  = PH_LOW;
				end
				PH_LOW: begin
					cmd_hi = rx;
					phase  = PH_HIGH;
				end
				PH_HIGH: begin
					sum = cmd_lo + cmd_hi;
					ang = command_angle(cmd_lo, cmd_hi);
					if (rx == sum && ang != 9'd0) begin
						credit_angle(ang);
						ev = EV_GOOD;
					end else begin
						rejected = rejected + 32'd1;
						ev = EV_BAD;
					end
					phase = (rx == SYNC_A) ? PH_GOTA : PH_HUNT;
				end
				default: begin
					phase = PH_HUNT;
				end
			endcase
		end
		item.frame_event  = ev;
		item.pad          = 5'd0;
		item.rejected     = rejected;
		item.accepted     = accepted;
		item.byte_count   = byte_count;
		item.repeat_count = run_len;
		item.cand_angle   = cand_angle;
		item.lock_angle   = lock_angle;
		item.latched      = latched;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
			mismatches = mismatches + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		status_item_t next_item;
		status_item_t want;
		status_item_t got;
		if (!arst_n) begin
			threshold = 8'd1;
			clear_parser();
			status_q.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tuser, m_axis_tdata};
				if (status_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result item with nothing outstanding", $realtime);
					mismatches = mismatches + 1;
				end else begin
					want = status_q.pop_front();
					check_field("frame_event", 32'(want.frame_event),
						32'(got.frame_event));
					check_field("latched", 32'(want.latched), 32'(got.latched));
					check_field("latched_angle", 32'(want.lock_angle),
						32'(got.lock_angle));
					check_field("candidate_angle", 32'(want.cand_angle),
						32'(got.cand_angle));
					check_field("repeat_count", 32'(want.repeat_count),
						32'(got.repeat_count));
					check_field("bytes_seen", want.byte_count, got.byte_count);
					check_field("valid_frames", want.accepted, got.accepted);
					check_field("rejected_frames", want.rejected, got.rejected);
					check_field("pad", 32'(want.pad), 32'(got.pad));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_parser(s_axis_tdata, s_axis_tuser, next_item);
				status_q.push_back(next_item);
			end
			outstanding = status_q.size();
		end
	end

endmodule

/* tb/framed_command_parser_with_latch_tb.sv */
// ----------------------------------------------------------------------------
// framed_command_parser_with_latch_tb
// Drives the frame parser with a short directed byte sequence and then with
// random phases of mostly well-formed frames, broken frames, noise and
// clears, under several confirm thresholds and random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_command_parser_with_latch_tb;

	import fcp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 230;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	wire          s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'd0;
	logic         s_axis_tuser = 1'b0;
	wire          m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	wire  [127:0] m_axis_tdata;
	wire  [1:0]   m_axis_tuser;
	logic         cfg_valid = 1'b0;
	wire          cfg_ready;
	logic [7:0]   cfg_data = 8'd0;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int bytes_sent = 0;
	int stall_left = 0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	logic [7:0] last_lo = 8'd1;

	framed_command_parser_with_latch dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	framed_command_parser_with_latch_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("framed_command_parser_with_latch test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (recv_idle && $urandom_range(0, 11) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 12);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic push_byte(input logic [7:0] rx, input logic clr);
		if (send_idle && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= rx;
		s_axis_tuser  <= clr;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic push_frame(input logic [7:0] kind, input logic [7:0] lo,
			input logic [7:0] hi, input logic [7:0] sum);
		push_byte(SYNC_A, 1'b0);
		push_byte(SYNC_B, 1'b0);
		push_byte(kind, 1'b0);
		push_byte(lo, 1'b0);
		push_byte(hi, 1'b0);
		push_byte(sum, 1'b0);
	endtask

	task automatic set_threshold(input logic [7:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int goal, input bit allow_idle);
		int pick;
		int kind;
		int n;
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] typ;
		goal = bytes_sent + goal;
		send_idle = allow_idle;
		recv_idle = allow_idle;
		while (bytes_sent < goal) begin
			if (allow_idle && $urandom_range(0, 15) == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				if ($urandom_range(0, 9) >= 7)
					last_lo = 8'($urandom_range(1, 4));
				push_frame(TYPE_CMD, last_lo, 8'd0, last_lo);
			end else if (pick < 80) begin
				lo = 8'($urandom_range(1, 4));
				hi = 8'd0;
				kind = $urandom_range(0, 6);
				case (kind)
					0: push_frame(TYPE_CMD, lo, hi, lo + hi + 8'($urandom_range(1, 255)));
					1: begin
						hi = 8'($urandom_range(1, 255));
						push_frame(TYPE_CMD, lo, hi, lo + hi);
					end
					2: begin
						lo = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(5, 255));
						hi = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
						push_frame(TYPE_CMD, lo, hi, lo + hi);
					end
					3: push_frame(TYPE_CMD, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), SYNC_A);
					4: begin
						do typ = 8'($urandom_range(0, 255)); while (typ == TYPE_CMD);
						push_byte(SYNC_A, 1'b0);
						push_byte(SYNC_B, 1'b0);
						push_byte(typ, 1'b0);
					end
					5: begin
						push_byte(SYNC_A, 1'b0);
						push_byte(SYNC_B, 1'b0);
						push_byte(TYPE_CMD, 1'b0);
						push_byte(lo, 1'b0);
					end
					default: begin
						push_byte(SYNC_A, 1'b0);
						push_byte(SYNC_B, 1'b0);
						push_frame(TYPE_CMD, lo, hi, lo + hi);
					end
				endcase
			end else if (pick < 96) begin
				n = $urandom_range(1, 4);
				repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
			end else if (pick < 98) begin
				push_byte(SYNC_A, 1'b0);
				push_byte(SYNC_A, 1'b0);
			end else begin
				push_byte(8'($urandom_range(0, 255)), 1'b1);
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0] settings [7];
		settings = '{8'd0, 8'd255, 8'd2, 8'd3, 8'd1, 8'd1, 8'd4};
		settings[5] = 8'($urandom_range(1, 8));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 1'b0;
		recv_idle = 1'b0;
		push_frame(TYPE_CMD, 8'd1, 8'd0, 8'd1);
		push_frame(TYPE_CMD, 8'd2, 8'd0, 8'd2);
		push_byte(8'hFF, 1'b1);
		push_frame(TYPE_CMD, 8'h50, 8'h5A, SYNC_A);
		push_byte(SYNC_B, 1'b0);
		push_byte(TYPE_CMD, 1'b0);
		push_byte(8'd4, 1'b0);
		push_byte(8'd0, 1'b0);
		push_byte(8'd4, 1'b0);

		set_threshold(8'd0);
		push_byte(8'h00, 1'b1);
		push_frame(TYPE_CMD, 8'd3, 8'd0, 8'd3);

		run_phase(PHASE_ITEMS, 1'b1);
		foreach (settings[i]) begin
			set_threshold(settings[i]);
			run_phase(PHASE_ITEMS, (i != 6));
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("framed_command_parser_with_latch test passed");
		else
			$display("framed_command_parser_with_latch test failed");
		$finish;
	end

endmodule
